// ===== hw/rtl/muce_pkg.sv =====
// ---------------------------------------------------------------------------
// Multi-channel UART exchange package
// Shared types and constants for the exchange lanes, transmitter and top.
// ---------------------------------------------------------------------------
package muce_pkg;

   localparam int LINE_COUNT  = 8;     // receive lines visible on the item
   localparam int FRAME_BITS  = 10;    // start, eight data bits, stop
   localparam int ELAPSED_W   = 22;    // holds 4095 ms worth of microseconds
   localparam int TIME_W      = 24;    // sample and bit times within one exchange
   localparam int PERIOD_W    = 16;
   localparam int TIMEOUT_W   = 12;
   localparam int DELAY_W     = 20;
   localparam int USE_W       = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int MS_TICKS    = 1000;  // microseconds per millisecond

   localparam logic [PERIOD_W-1:0]  BIT_PERIOD_RESET = 16'd104;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET    = 12'd100;

   typedef enum logic {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BIT_PERIOD  = 2'd0,
      CSR_TIMEOUT     = 2'd1,
      CSR_TX_DELAY    = 2'd2,
      CSR_RX_IN_USE   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      RX_DISCONNECTED = 4'b0001,
      RX_WAITING      = 4'b0010,
      RX_RUNNING      = 4'b0100,
      RX_DONE         = 4'b1000
   } rx_mode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  tx_byte;
      logic [7:0]  rx_levels;
   } req_payload_type;

   typedef struct packed {
      logic        tx_line;
      logic        exchange_active;
      logic [7:0]  done_mask;
      logic [7:0]  connected_mask;
      logic [63:0] received_bytes;
   } rsp_payload_type;

   // Control handed from the top level to each receive lane.
   typedef struct packed {
      logic                start;
      logic                tick;
      logic                in_use;
      logic                level;
      logic [TIME_W-1:0]   now;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W:0]   period_1p5;
   } lane_ctrl_type;

   // What a lane reports back to the merging stage.
   typedef struct packed {
      logic       busy_now;
      logic       busy_next;
      logic       connected;
      logic       done;
      logic [7:0] data;
   } lane_status_type;

   typedef struct packed {
      logic level;
      logic active_now;
      logic active_next;
   } tx_status_type;

endpackage

// ===== hw/rtl/muce_rx_lane.sv =====
// ---------------------------------------------------------------------------
// Receive lane
// One 8N1 receiver: waits for the start edge, then samples eight data bits.
// ---------------------------------------------------------------------------
module muce_rx_lane
   import muce_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  lane_ctrl_type   ctrl,
   output lane_status_type status
);

   rx_mode_type       mode_ff,  mode_in;
   logic [7:0]        byte_ff,  byte_in;
   logic [2:0]        cnt_ff,   cnt_in;
   logic [TIME_W-1:0] next_ff,  next_in;

   always_comb begin
      mode_in = mode_ff;
      byte_in = byte_ff;
      cnt_in  = cnt_ff;
      next_in = next_ff;
      if (ctrl.start) begin
         if (ctrl.in_use && ctrl.level) begin
            mode_in = RX_WAITING;
            byte_in = 8'd0;
            cnt_in  = 3'd0;
         end else begin
            mode_in = RX_DISCONNECTED;
         end
      end else if (ctrl.tick) begin
         unique case (mode_ff)
            RX_WAITING: begin
               if (!ctrl.level) begin
                  mode_in = RX_RUNNING;
                  next_in = ctrl.now + TIME_W'(ctrl.period_1p5);
               end
            end
            RX_RUNNING: begin
               if (next_ff <= ctrl.now) begin
                  byte_in = byte_ff | (8'(ctrl.level) << cnt_ff);
                  cnt_in  = cnt_ff + 3'd1;
                  next_in = next_ff + TIME_W'(ctrl.period);
                  if (cnt_ff == 3'd7) begin
                     mode_in = RX_DONE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= RX_DISCONNECTED;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      cnt_ff  <= cnt_in;
      next_ff <= next_in;
   end

   assign status.busy_now  = (mode_ff == RX_WAITING) || (mode_ff == RX_RUNNING);
   assign status.busy_next = (mode_in == RX_WAITING) || (mode_in == RX_RUNNING);
   assign status.connected = (mode_in != RX_DISCONNECTED);
   assign status.done      = (mode_in == RX_DONE);
   assign status.data      = byte_in;

endmodule

// ===== hw/rtl/muce_tx.sv =====
// ---------------------------------------------------------------------------
// Transmitter
// Shifts out one 8N1 frame, one bit per bit period after the start delay.
// ---------------------------------------------------------------------------
module muce_tx
   import muce_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                tick,
   input  logic [7:0]          tx_byte,
   input  logic [DELAY_W-1:0]  delay,
   input  logic [TIME_W-1:0]   now,
   input  logic [PERIOD_W-1:0] period,
   output tx_status_type       status
);

   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [3:0]            count_ff, count_in;
   logic [TIME_W-1:0]     next_ff,  next_in;
   logic                  level_ff, level_in;

   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      next_in  = next_ff;
      level_in = level_ff;
      if (start) begin
         frame_in = {1'b1, tx_byte, 1'b0};
         count_in = 4'd0;
         next_in  = TIME_W'(delay);
         level_in = 1'b1;
      end else if (tick && (next_ff <= now) && (count_ff < 4'(FRAME_BITS))) begin
         level_in = frame_ff[count_ff];
         count_in = count_ff + 4'd1;
         next_in  = next_ff + TIME_W'(period);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '1;
         count_ff <= 4'(FRAME_BITS);
         next_ff  <= '0;
         level_ff <= 1'b1;
      end else begin
         frame_ff <= frame_in;
         count_ff <= count_in;
         next_ff  <= next_in;
         level_ff <= level_in;
      end
   end

   assign status.level       = level_in;
   assign status.active_now  = (count_ff < 4'(FRAME_BITS));
   assign status.active_next = (count_in < 4'(FRAME_BITS));

endmodule

// ===== hw/rtl/multi_channel_uart_exchange_top.sv =====
// ---------------------------------------------------------------------------
// Multi-channel UART exchange, top level
// One 8N1 transmitter and parallel 8N1 receive lanes run as a timed exchange.
// ---------------------------------------------------------------------------
// The block takes one item per clock while its skid register is empty and
// returns exactly one result item for each. Each result is registered as its
// item is taken, so it can go out in the next cycle unless the output stalls.
// A start item loads the transmit byte, marks every in-use receive line that
// is high as waiting and clears the elapsed time. Each tick item is one
// microsecond of sampled line levels; it advances the exchange only while
// the elapsed time is below the timeout and a receiver is still pending or
// transmit bits remain. All receive lanes and the transmitter update in the
// same cycle, so the block can take one item every clock while not stalled.
// The result carries the transmit line level, whether the exchange is
// still active, the done and connected masks, and the received bytes (zero
// for lanes that have not finished). An output register backed by a one-item
// skid register lets the block take a new item while a result waits to be
// taken. The bit period and timeout act at once when written; the transmit
// delay and the number of receivers in use take effect at the next start.
// ---------------------------------------------------------------------------
module multi_channel_uart_exchange_top
   import muce_pkg::*;
#(
   parameter int NUM_RECEIVERS = 8
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // The item carries eight line levels, so receivers above the eighth could
   // never connect; only the lanes that can see a line are built.
   localparam int NUM_LANES = (NUM_RECEIVERS < LINE_COUNT) ? NUM_RECEIVERS : LINE_COUNT;

   // Configuration registers. The 1.5 bit period used when a receiver arms is
   // kept alongside the bit period so the arming add has only two operands.
   logic [PERIOD_W-1:0]  period_ff,     period_in;
   logic [PERIOD_W:0]    period_1p5_ff, period_1p5_in;
   logic [TIMEOUT_W-1:0] timeout_ff,    timeout_in;
   logic [DELAY_W-1:0]   delay_ff,      delay_in;
   logic [USE_W-1:0]     in_use_ff,     in_use_in;

   always_comb begin
      period_in     = period_ff;
      period_1p5_in = period_1p5_ff;
      timeout_in    = timeout_ff;
      delay_in      = delay_ff;
      in_use_in     = in_use_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BIT_PERIOD: begin
               period_in     = csr_data[PERIOD_W-1:0];
               period_1p5_in = (PERIOD_W+1)'(csr_data[PERIOD_W-1:0])
                             + (PERIOD_W+1)'(csr_data[PERIOD_W-1:1]);
            end
            CSR_TIMEOUT: begin
               timeout_in = csr_data[TIMEOUT_W-1:0];
            end
            CSR_TX_DELAY: begin
               delay_in = csr_data[DELAY_W-1:0];
            end
            CSR_RX_IN_USE: begin
               in_use_in = csr_data[USE_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= BIT_PERIOD_RESET;
         period_1p5_ff <= (PERIOD_W+1)'(BIT_PERIOD_RESET) + (PERIOD_W+1)'(BIT_PERIOD_RESET >> 1);
         timeout_ff    <= TIMEOUT_RESET;
         delay_ff      <= '0;
         in_use_ff     <= '0;
      end else begin
         period_ff     <= period_in;
         period_1p5_ff <= period_1p5_in;
         timeout_ff    <= timeout_in;
         delay_ff      <= delay_in;
         in_use_ff     <= in_use_in;
      end
   end

   // Handshake. The skid register catches the item accepted while the output
   // register is held, so input is stalled only when the skid is occupied or
   // while reset is held.
   logic            req_accept;
   logic            out_free;
   logic            rsp_valid_ff;
   logic            skid_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type skid_payload_ff;
   rsp_payload_type result_c;

   assign req_stall  = skid_valid_ff || reset;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Exchange timing. The elapsed count never passes the timeout limit, so
   // every time value in one exchange fits the narrow time width.
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [ELAPSED_W-1:0] limit_c;
   logic [TIME_W-1:0]    now_c;
   logic                 any_busy_now;
   logic                 any_busy_next;
   logic                 running_now;
   logic                 start_c;
   logic                 tick_c;
   tx_status_type        tx_status;

   assign limit_c     = ELAPSED_W'(timeout_ff) * ELAPSED_W'(MS_TICKS);
   assign now_c       = TIME_W'(elapsed_ff) + TIME_W'(1);
   assign running_now = (elapsed_ff < limit_c) && (any_busy_now || tx_status.active_now);
   assign start_c     = req_accept && (req_payload.opcode == OP_START);
   assign tick_c      = req_accept && (req_payload.opcode == OP_TICK) && running_now;

   always_comb begin
      elapsed_in = elapsed_ff;
      if (start_c) begin
         elapsed_in = '0;
      end else if (tick_c) begin
         elapsed_in = elapsed_ff + ELAPSED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
      end
   end

   // Receive lanes, one per visible line, all stepping on the same tick.
   lane_ctrl_type   lane_ctrl   [NUM_LANES];
   lane_status_type lane_status [NUM_LANES];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      assign lane_ctrl[i].start      = start_c;
      assign lane_ctrl[i].tick       = tick_c;
      assign lane_ctrl[i].in_use     = (in_use_ff > USE_W'(i));
      assign lane_ctrl[i].level      = req_payload.rx_levels[i];
      assign lane_ctrl[i].now        = now_c;
      assign lane_ctrl[i].period     = period_ff;
      assign lane_ctrl[i].period_1p5 = period_1p5_ff;

      muce_rx_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl[i]),
         .status (lane_status[i])
      );
   end

   muce_tx u_tx (
      .clock   (clock),
      .reset   (reset),
      .start   (start_c),
      .tick    (tick_c),
      .tx_byte (req_payload.tx_byte),
      .delay   (delay_ff),
      .now     (now_c),
      .period  (period_ff),
      .status  (tx_status)
   );

   // Merging stage: gather lane reports into masks and the byte word. The
   // result describes the state after the item, so it uses next-state reports.
   logic [7:0]  done_c;
   logic [7:0]  conn_c;
   logic [63:0] bytes_c;

   always_comb begin
      done_c        = '0;
      conn_c        = '0;
      bytes_c       = '0;
      any_busy_now  = 1'b0;
      any_busy_next = 1'b0;
      for (int j = 0; j < NUM_LANES; j++) begin
         done_c[j]           = lane_status[j].done;
         conn_c[j]           = lane_status[j].connected;
         bytes_c[8*j +: 8]   = lane_status[j].done ? lane_status[j].data : 8'd0;
         any_busy_now        = any_busy_now  | lane_status[j].busy_now;
         any_busy_next       = any_busy_next | lane_status[j].busy_next;
      end
   end

   assign result_c.tx_line         = tx_status.level;
   assign result_c.exchange_active = (elapsed_in < limit_c)
                                   && (any_busy_next || tx_status.active_next);
   assign result_c.done_mask       = done_c;
   assign result_c.connected_mask  = conn_c;
   assign result_c.received_bytes  = bytes_c;

   // Output register and skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff || req_accept;
         skid_valid_ff <= 1'b0;
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_payload_ff <= skid_valid_ff ? skid_payload_ff : result_c;
      end
      if (!out_free && req_accept) begin
         skid_payload_ff <= result_c;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== test/multi_channel_uart_exchange_top_tb.sv =====
// ---------------------------------------------------------------------------
// Multi-channel UART exchange, top-level testbench
// Drives start and tick items into the exchange block, predicts every result
// item with a cycle-free model of the transmitter and receive lanes, and
// checks each result field by field while both channels idle and stall.
// ---------------------------------------------------------------------------
module multi_channel_uart_exchange_top_tb;
   import muce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset = 1'b1;

   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   multi_channel_uart_exchange_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Register copies held by the predictor. They start at the reset values
   // of the block and follow every write made through write_register.
   logic [PERIOD_W-1:0]  cfg_period  = BIT_PERIOD_RESET;
   logic [TIMEOUT_W-1:0] cfg_timeout = TIMEOUT_RESET;
   logic [DELAY_W-1:0]   cfg_delay   = '0;
   logic [USE_W-1:0]     cfg_in_use  = '0;

   // Exchange state of the predictor. Times are kept at 32 bits; within one
   // exchange they never come near the width of the block's own counters.
   logic [31:0]  elapsed       = '0;
   logic [9:0]   tx_frame      = '1;
   int unsigned  tx_bits_sent  = FRAME_BITS;
   logic [31:0]  tx_next_time  = '0;
   logic         tx_level      = 1'b1;
   int unsigned  lanes_pending = 0;
   rx_mode_type  lane_mode   [LINE_COUNT] = '{default: RX_DISCONNECTED};
   logic [7:0]   lane_byte   [LINE_COUNT] = '{default: 8'h00};
   int unsigned  lane_bits   [LINE_COUNT] = '{default: 0};
   logic [31:0]  lane_sample [LINE_COUNT] = '{default: 32'h0};

   rsp_payload_type expected_results [$];
   int unsigned     items_sent     = 0;
   int unsigned     mismatch_count = 0;
   int unsigned     sender_idle_pct    = 0;
   int unsigned     receiver_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run can never legitimately take this long; reaching it means the
   // block stopped taking items or stopped returning results.
   initial begin
      #(2_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Predictor
   // -------------------------------------------------------------------------

   // The exchange keeps going while time is left and either a lane still
   // waits for its byte or the transmit frame is not fully out.
   function automatic logic exchange_running();
      logic [31:0] limit;
      limit = 32'(cfg_timeout) * 32'(MS_TICKS);
      return (elapsed < limit) && ((lanes_pending > 0) || (tx_bits_sent < FRAME_BITS));
   endfunction

   // Applies one item to the predicted exchange state and returns the result
   // item that the block has to produce for it.
   function automatic rsp_payload_type predict_exchange(req_payload_type it);
      rsp_payload_type r;
      int unsigned     used;
      int unsigned     i;
      logic [31:0]     p;
      logic [31:0]     t;
      logic            lv;
      if (it.opcode == OP_START) begin
         // Lanes beyond the supported count are treated as absent, and a
         // lane is only connected when its line idles high at start.
         used = (cfg_in_use > LINE_COUNT) ? LINE_COUNT : cfg_in_use;
         tx_level      = 1'b1;
         lanes_pending = 0;
         for (i = 0; i < LINE_COUNT; i++) begin
            if (i < used && it.rx_levels[i]) begin
               lane_mode[i] = RX_WAITING;
               lane_byte[i] = 8'h00;
               lane_bits[i] = 0;
               lanes_pending++;
            end else begin
               lane_mode[i] = RX_DISCONNECTED;
            end
         end
         elapsed      = '0;
         tx_frame     = {1'b1, it.tx_byte, 1'b0};
         tx_bits_sent = 0;
         tx_next_time = 32'(cfg_delay);
      end else if (exchange_running()) begin
         p = 32'(cfg_period);
         elapsed++;
         t = elapsed;
         for (i = 0; i < LINE_COUNT; i++) begin
            lv = it.rx_levels[i];
            if (lane_mode[i] == RX_WAITING && !lv) begin
               // Falling edge of the start bit: first sample lands in the
               // middle of data bit zero.
               lane_mode[i]   = RX_RUNNING;
               lane_sample[i] = t + p + p / 2;
            end else if (lane_mode[i] == RX_RUNNING && lane_sample[i] <= t) begin
               lane_byte[i][lane_bits[i] % 8] = lane_byte[i][lane_bits[i] % 8] | lv;
               lane_bits[i]++;
               lane_sample[i] += p;
               if (lane_bits[i] >= 8) begin
                  lane_mode[i] = RX_DONE;
                  if (lanes_pending > 0) lanes_pending--;
               end
            end
         end
         if (tx_next_time <= t && tx_bits_sent < FRAME_BITS) begin
            tx_level = tx_frame[tx_bits_sent];
            tx_bits_sent++;
            tx_next_time += p;
         end
      end
      r = '0;
      r.tx_line         = tx_level;
      r.exchange_active = exchange_running();
      for (i = 0; i < LINE_COUNT; i++) begin
         r.connected_mask[i] = (lane_mode[i] != RX_DISCONNECTED);
         if (lane_mode[i] == RX_DONE) begin
            r.done_mask[i]            = 1'b1;
            r.received_bytes[8*i +: 8] = lane_byte[i];
         end
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------

   // Values are read in the active region of the edge, so they are the ones
   // the block itself saw at that edge.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: result item arrived with none expected", $time);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (want.tx_line !== rsp_payload.tx_line ||
                want.exchange_active !== rsp_payload.exchange_active ||
                want.done_mask !== rsp_payload.done_mask ||
                want.connected_mask !== rsp_payload.connected_mask ||
                want.received_bytes !== rsp_payload.received_bytes) begin
               if (mismatch_count < 10) begin
                  $display("%0t: result mismatch", $time);
                  $display("   expected tx %b active %b done %h conn %h bytes %h",
                           want.tx_line, want.exchange_active, want.done_mask,
                           want.connected_mask, want.received_bytes);
                  $display("   actual   tx %b active %b done %h conn %h bytes %h",
                           rsp_payload.tx_line, rsp_payload.exchange_active,
                           rsp_payload.done_mask, rsp_payload.connected_mask,
                           rsp_payload.received_bytes);
               end
               mismatch_count++;
            end
         end
      end
   end

   // The result side stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Offers one item, possibly after some idle cycles, and records the
   // expected result at the edge where the block takes it.
   task automatic send_item(input req_payload_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_exchange(it));
      items_sent++;
   endtask

   task automatic send_start(input logic [7:0] tx_byte, input logic [7:0] levels);
      req_payload_type it;
      it.opcode    = OP_START;
      it.tx_byte   = tx_byte;
      it.rx_levels = levels;
      send_item(it);
   endtask

   // The transmit byte of a tick is ignored by the block, so it is random.
   task automatic send_tick(input logic [7:0] levels);
      req_payload_type it;
      it.opcode    = OP_TICK;
      it.tx_byte   = 8'($urandom);
      it.rx_levels = levels;
      send_item(it);
   endtask

   // Stops offering items and waits until every expected result is back, then
   // lets the output stages empty.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_BIT_PERIOD: cfg_period  = PERIOD_W'(value);
         CSR_TIMEOUT:    cfg_timeout = TIMEOUT_W'(value);
         CSR_TX_DELAY:   cfg_delay   = DELAY_W'(value);
         CSR_RX_IN_USE:  cfg_in_use  = USE_W'(value);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input int unsigned period, input int unsigned timeout,
                                 input int unsigned delay, input int unsigned in_use);
      settle_block();
      write_register(CSR_BIT_PERIOD, period);
      write_register(CSR_TIMEOUT, timeout);
      write_register(CSR_TX_DELAY, delay);
      write_register(CSR_RX_IN_USE, in_use);
   endtask

   // Slow settings use long bit periods and a one millisecond limit, so that
   // some frames finish just in time and others are cut by the timeout.
   task automatic choose_random_settings(input bit slow_lines);
      int unsigned period;
      int unsigned in_use;
      if (slow_lines)
         period = $urandom_range(80, 110);
      else
         period = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      in_use = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      apply_settings(period, slow_lines ? 1 : $urandom_range(1, 4000),
                     slow_lines ? $urandom_range(0, 50) : $urandom_range(0, 20), in_use);
   endtask

   // One exchange with properly framed 8N1 bytes on every line: each line
   // idles high for a short gap, then sends start, eight data bits and stop
   // at the configured bit period. Some exchanges carry glitches, some are
   // pure noise and some are cut short by the next start.
   task automatic run_line_exchange();
      int unsigned p_eff;
      int unsigned gap [LINE_COUNT];
      int unsigned tick_total;
      int unsigned noise_pct;
      int unsigned n;
      int unsigned k;
      int unsigned i;
      logic [7:0]  line_data [LINE_COUNT];
      logic [7:0]  start_levels;
      logic [7:0]  levels;
      bit          pure_noise;
      p_eff      = (cfg_period == 0) ? 1 : cfg_period;
      pure_noise = ($urandom_range(0, 9) == 0);
      noise_pct  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      for (i = 0; i < LINE_COUNT; i++) begin
         line_data[i]    = 8'($urandom);
         gap[i]          = $urandom_range(0, p_eff + 2);
         start_levels[i] = ($urandom_range(0, 99) < 85);
      end
      tick_total = 11 * p_eff + 2;
      if (cfg_delay + 10 * p_eff > tick_total) tick_total = cfg_delay + 10 * p_eff;
      tick_total += $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) tick_total = $urandom_range(1, tick_total);
      send_start(8'($urandom), start_levels);
      for (n = 0; n < tick_total; n++) begin
         if (pure_noise) begin
            levels = 8'($urandom);
         end else begin
            for (i = 0; i < LINE_COUNT; i++) begin
               if (n < gap[i]) begin
                  levels[i] = 1'b1;
               end else begin
                  k = (n - gap[i]) / p_eff;
                  levels[i] = (k == 0) ? 1'b0 : (k <= 8) ? line_data[i][k-1] : 1'b1;
               end
            end
         end
         if ($urandom_range(0, 99) < noise_pct) begin
            k = $urandom_range(0, 7);
            levels[k] = ~levels[k];
         end
         send_tick(levels);
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Right after reset the exchange is over, so a tick changes nothing. A
   // start with no receivers in use still starts the transmit frame.
   task automatic test_after_reset();
      send_tick(8'hFF);
      send_start(8'h00, 8'hFF);
      send_tick(8'h00);
   endtask

   // Largest bit period, a large timeout and delay, and a receiver count above the
   // number of lanes: every lane connects, arms and waits, while the
   // transmit line stays idle through the long delay.
   task automatic test_register_extremes();
      apply_settings(65535, 4000, 1000000, 15);
      send_start(8'hFF, 8'hFF);
      send_tick(8'h00);
      send_tick(8'hFF);
      send_start(8'h00, 8'h00);
      send_tick(8'h00);
   endtask

   // With a zero timeout no tick may advance the exchange.
   task automatic test_zero_timeout();
      apply_settings(1, 0, 0, 8);
      send_start(8'h5A, 8'hFF);
      send_tick(8'h00);
   endtask

   // A bit period of zero makes every lane sample and the transmitter send a
   // bit on each tick. The frame ends after ten ticks, and the ticks after
   // that must return the same result unchanged.
   task automatic test_zero_bit_period();
      int unsigned n;
      apply_settings(0, 1, 0, 9);
      send_start(8'hA5, 8'hFF);
      send_tick(8'h00);
      for (n = 0; n < 8; n++) send_tick(8'($urandom));
      repeat (3) send_tick(8'hFF);
   endtask

   // Bit period and timeout act at once, while the receiver count and the
   // transmit delay only act at the next start.
   task automatic test_mid_exchange_writes();
      apply_settings(3, 1, 5, 2);
      send_start(8'($urandom), 8'h03);
      repeat (4) send_tick(8'h02);
      settle_block();
      write_register(CSR_BIT_PERIOD, 1);
      write_register(CSR_RX_IN_USE, 8);
      write_register(CSR_TX_DELAY, 0);
      repeat (4) send_tick(8'($urandom));
      send_start(8'($urandom), 8'hFF);
      send_tick(8'h00);
   endtask

   // Mostly framed exchanges with random content, mixed with stray items and
   // new register settings taken between exchanges.
   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned budget, input bit slow_lines);
      int unsigned stop_at;
      int unsigned n;
      req_payload_type it;
      choose_random_settings(slow_lines);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               for (n = $urandom_range(1, 4); n > 0; n--) begin
                  it.opcode    = opcode_type'($urandom_range(0, 1));
                  it.tx_byte   = 8'($urandom);
                  it.rx_levels = 8'($urandom);
                  send_item(it);
               end
            end
            1: if (!slow_lines) choose_random_settings(1'b0);
            default: run_line_exchange();
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_register_extremes();
      test_zero_timeout();
      test_zero_bit_period();
      test_mid_exchange_writes();

      test_random_traffic(0, 0, 120, 1'b0);
      test_random_traffic(53, 0, 120, 1'b0);
      test_random_traffic(0, 53, 120, 1'b0);
      test_random_traffic(32, 32, 120, 1'b1);
      test_random_traffic(32, 32, 120, 1'b0);

      settle_block();
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
